>>> sv/ups_serial_frame_receiver_top_assert.svh
//------------------------------------------------------------------------------
// UPS serial frame receiver assertion macros
// Concurrent assertion wrappers shared by the receiver modules. They sample
// on clk and are disabled while rst_n is low.
//------------------------------------------------------------------------------
`ifndef UPS_SERIAL_FRAME_RECEIVER_TOP_ASSERT_SVH
`define UPS_SERIAL_FRAME_RECEIVER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define UPS_SFR_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ups_sfr: same-cycle check failed");

// Next-cycle implication.
`define UPS_SFR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ups_sfr: next-cycle check failed");

`else

`define UPS_SFR_ASSERT_IMPLY(label, ante, cons)
`define UPS_SFR_ASSERT_NEXT(label, ante, cons)

`endif

`endif

>>> sv/ups_sfr_pkg.sv
//------------------------------------------------------------------------------
// UPS serial frame receiver package
// Widths, status codes and the result record shared by the receiver modules.
//------------------------------------------------------------------------------
`default_nettype none

package ups_sfr_pkg;

    // Framing constants.
    localparam logic [7:0] START_BYTE  = 8'h02;
    localparam logic [9:0] HUNT_RESET  = 10'd256;
    localparam logic [7:0] MIN_LENGTH  = 8'd2;

    // Configuration register indexes.
    localparam logic CFG_EXPECTED_COMMAND = 1'b0;
    localparam logic CFG_HUNT_LIMIT       = 1'b1;

    localparam int CFG_DATA_W = 10;
    localparam int OUT_DATA_W = 24;

    // Frame status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_CMD  = 3'd1;
    localparam logic [2:0] ST_BAD_SUM  = 3'd2;
    localparam logic [2:0] ST_BAD_LEN  = 3'd3;
    localparam logic [2:0] ST_NO_START = 3'd4;
    localparam logic [2:0] ST_READ_ERR = 3'd5;

    // One result item.
    typedef struct packed {
        logic [7:0] body_byte;
        logic       frame_end;
        logic [2:0] status;
        logic [7:0] body_count;
    } sfr_result_t;

endpackage

`default_nettype wire

>>> sv/ups_sfr_core.sv
//------------------------------------------------------------------------------
// UPS serial frame receiver core
// Frame state machine: start hunt, length, body and checksum checking. Holds
// the configuration registers and produces at most one result per byte.
//------------------------------------------------------------------------------
`default_nettype none
`include "ups_serial_frame_receiver_top_assert.svh"

module ups_sfr_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic                              cfg_index,
    input  wire logic [ups_sfr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                              in_take,
    input  wire logic                              in_abort,
    input  wire logic [7:0]                        in_byte,
    output logic                                   res_valid,
    output ups_sfr_pkg::sfr_result_t               res
);

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_LEN  = 2'd1,
        PH_BODY = 2'd2,
        PH_SUM  = 2'd3
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [9:0] hunt_count_reg, hunt_count_next;
    logic [7:0] bytes_left_reg, bytes_left_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic       first_seen_reg, first_seen_next;
    logic       cmd_match_reg, cmd_match_next;
    logic [7:0] delivered_reg, delivered_next;
    logic [7:0] expected_cmd_reg;
    logic [9:0] hunt_limit_reg;
    logic [9:0] hunt_inc;
    logic [7:0] left_dec;
    logic       finish;
    logic [2:0] finish_status;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_cmd_reg <= 8'd0;
            hunt_limit_reg   <= ups_sfr_pkg::HUNT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ups_sfr_pkg::CFG_EXPECTED_COMMAND: expected_cmd_reg <= cfg_data[7:0];
                ups_sfr_pkg::CFG_HUNT_LIMIT:       hunt_limit_reg   <= cfg_data;
                default:                           hunt_limit_reg   <= hunt_limit_reg;
            endcase
        end
    end

    assign hunt_inc = hunt_count_reg + 10'd1;
    assign left_dec = bytes_left_reg - 8'd1;

    // Per-byte update of the frame state and the result it causes.
    always_comb
    begin
        phase_next       = phase_reg;
        hunt_count_next  = hunt_count_reg;
        bytes_left_next  = bytes_left_reg;
        running_sum_next = running_sum_reg;
        first_seen_next  = first_seen_reg;
        cmd_match_next   = cmd_match_reg;
        delivered_next   = delivered_reg;
        finish           = 1'b0;
        finish_status    = ups_sfr_pkg::ST_OK;
        res_valid        = 1'b0;
        res              = '0;

        if (in_take)
        begin
            if (in_abort)
            begin
                finish        = 1'b1;
                finish_status = ups_sfr_pkg::ST_READ_ERR;
            end
            else
            begin
                unique case (phase_reg)
                    PH_HUNT:
                    begin
                        if (in_byte == ups_sfr_pkg::START_BYTE)
                        begin
                            hunt_count_next = 10'd0;
                            phase_next      = PH_LEN;
                        end
                        else if (hunt_inc >= hunt_limit_reg)
                        begin
                            finish        = 1'b1;
                            finish_status = ups_sfr_pkg::ST_NO_START;
                        end
                        else
                        begin
                            hunt_count_next = hunt_inc;
                        end
                    end
                    PH_LEN:
                    begin
                        if (in_byte < ups_sfr_pkg::MIN_LENGTH)
                        begin
                            finish        = 1'b1;
                            finish_status = ups_sfr_pkg::ST_BAD_LEN;
                        end
                        else
                        begin
                            running_sum_next = in_byte;
                            bytes_left_next  = in_byte - 8'd1;
                            delivered_next   = 8'd0;
                            first_seen_next  = 1'b0;
                            cmd_match_next   = 1'b0;
                            phase_next       = PH_BODY;
                        end
                    end
                    PH_BODY:
                    begin
                        if (!first_seen_reg)
                        begin
                            cmd_match_next  = (in_byte == expected_cmd_reg);
                            first_seen_next = 1'b1;
                        end
                        running_sum_next = running_sum_reg + in_byte;
                        delivered_next   = delivered_reg + 8'd1;
                        bytes_left_next  = left_dec;
                        if (left_dec == 8'd0)
                        begin
                            phase_next = PH_SUM;
                        end
                        res_valid     = 1'b1;
                        res.body_byte = in_byte;
                    end
                    PH_SUM:
                    begin
                        finish = 1'b1;
                        if (!cmd_match_reg)
                        begin
                            finish_status = ups_sfr_pkg::ST_BAD_CMD;
                        end
                        else if (in_byte != running_sum_reg)
                        begin
                            finish_status = ups_sfr_pkg::ST_BAD_SUM;
                        end
                        else
                        begin
                            finish_status = ups_sfr_pkg::ST_OK;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_HUNT;
                    end
                endcase
            end

            // A status result closes the attempt and clears the frame state.
            if (finish)
            begin
                res_valid        = 1'b1;
                res.frame_end    = 1'b1;
                res.status       = finish_status;
                res.body_count   = delivered_reg;
                phase_next       = PH_HUNT;
                hunt_count_next  = 10'd0;
                bytes_left_next  = 8'd0;
                running_sum_next = 8'd0;
                first_seen_next  = 1'b0;
                cmd_match_next   = 1'b0;
                delivered_next   = 8'd0;
            end
        end
    end

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HUNT;
            hunt_count_reg  <= 10'd0;
            bytes_left_reg  <= 8'd0;
            running_sum_reg <= 8'd0;
            first_seen_reg  <= 1'b0;
            cmd_match_reg   <= 1'b0;
            delivered_reg   <= 8'd0;
        end
        else
        begin
            phase_reg       <= phase_next;
            hunt_count_reg  <= hunt_count_next;
            bytes_left_reg  <= bytes_left_next;
            running_sum_reg <= running_sum_next;
            first_seen_reg  <= first_seen_next;
            cmd_match_reg   <= cmd_match_next;
            delivered_reg   <= delivered_next;
        end
    end

    // A closing status always leaves the receiver hunting again.
    `UPS_SFR_ASSERT_NEXT(a_end_to_hunt, res_valid && res.frame_end, phase_reg == PH_HUNT && delivered_reg == 8'd0)
    // No body bytes are counted while hunting.
    `UPS_SFR_ASSERT_IMPLY(a_hunt_no_body, phase_reg == PH_HUNT, delivered_reg == 8'd0 && bytes_left_reg == 8'd0)
    // Body results come only from the body phase.
    `UPS_SFR_ASSERT_IMPLY(a_body_phase, res_valid && !res.frame_end, phase_reg == PH_BODY && res.status == ups_sfr_pkg::ST_OK)

endmodule

`default_nettype wire

>>> sv/ups_serial_frame_receiver_top.sv
//------------------------------------------------------------------------------
// UPS serial frame receiver top level
// Byte stream in, body bytes and one closing status per frame attempt out.
//------------------------------------------------------------------------------
// Usage:
//   The slave stream carries one serial byte per transfer in s_tdata, with
//   s_tuser high for an abort (read error or timeout). The master stream
//   carries one result per transfer: a body byte, or with m_tlast high the
//   closing status and the count of body bytes delivered.
//   A result caused by a byte is registered in the output stage, in the result
//   register or, while the master side stalls, in the skid register. Throughput
//   is one byte per cycle while s_tready is high.
//   A two-entry output stage (result register plus skid register) keeps the
//   input open while one result waits; s_tready drops only when both hold
//   results, and rises again as soon as the downstream side takes one.
//   Configuration writes are taken at any edge with cfg_we high and should
//   only be made while the receiver is idle.
//   Reset clears the frame state, empties the output stage, sets the
//   expected command to zero and the hunt limit to 256.
//------------------------------------------------------------------------------
`default_nettype none
`include "ups_serial_frame_receiver_top_assert.svh"

module ups_serial_frame_receiver_top (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // Configuration write port: index 0 expected command, index 1 hunt limit.
    input  wire logic                                cfg_we,
    input  wire logic                                cfg_index,
    input  wire logic [ups_sfr_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Slave stream.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,  // [7:0] rx_byte
    input  wire logic                                s_tuser,  // [0] op (1 = abort)
    // Master stream.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [ups_sfr_pkg::OUT_DATA_W-1:0]       m_tdata,  // [7:0] body_byte,
                                                               // [10:8] status,
                                                               // [18:11] body_count,
                                                               // [23:19] zero
    output logic                                     m_tlast   // frame_end
);

    logic                     in_take;
    logic                     res_valid;
    ups_sfr_pkg::sfr_result_t res;
    logic                     out_valid_reg;
    ups_sfr_pkg::sfr_result_t out_data_reg;
    logic                     skid_valid_reg;
    ups_sfr_pkg::sfr_result_t skid_data_reg;
    logic                     out_free;

    assign s_tready = !skid_valid_reg;
    assign in_take  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    ups_sfr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_take   (in_take),
        .in_abort  (s_tuser),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    // Output stage valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || res_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output stage payload; the skid entry is older than any new result.
    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : res;
        end
        else if (res_valid)
        begin
            skid_data_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_data_reg.frame_end;
    assign m_tdata  = {5'd0, out_data_reg.body_count, out_data_reg.status,
                       out_data_reg.body_byte};

    // The skid entry is only ever filled behind a waiting result.
    `UPS_SFR_ASSERT_IMPLY(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    // A result arriving while the output is stalled lands in the skid entry.
    `UPS_SFR_ASSERT_NEXT(a_stall_to_skid, res_valid && out_valid_reg && !m_tready, skid_valid_reg && out_valid_reg)
    // A result with free output space is offered next cycle.
    `UPS_SFR_ASSERT_NEXT(a_result_shown, res_valid && out_free, out_valid_reg)

endmodule

`default_nettype wire
